// ----- rtl/bd2_pkg.sv -----
// Shared constants for the 2x2 box-filter downsampler.
`timescale 1ns / 1ps

package bd2_pkg;

  localparam int PIX_W             = 8;
  localparam int CFG_W             = 13;
  localparam int CFG_IDX_W         = 1;
  localparam int ROW_W             = 12;
  localparam int MAX_HEIGHT        = 4096;
  localparam int MAX_WIDTH_DEFAULT = 4096;
  localparam int RESET_WIDTH       = 640;
  localparam int RESET_HEIGHT      = 480;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

endpackage

// ----- rtl/box_downsample_2x2.sv -----
// Top level of the 2x2 box-filter downsampler with its line store of pair sums.
`timescale 1ns / 1ps

// Path: the transfer of the pixel that completes a 2x2 block registers the line-store read
// and its pair sum in stage one; the add of the two then goes into the output register.
// Throughput: one source pixel per cycle; the single-port read/write line store and the
// two result registers sustain that as long as the result side keeps taking transfers.
// Reset: counters and valid flags clear, frame size returns to 640 x 480; the line store
// is not cleared, since every entry is written on an even row before it is read.
module box_downsample_2x2 #(
  parameter int MAX_WIDTH = bd2_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bd2_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bd2_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] pixel_in
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [7:0] pixel_out
  output logic                          m_tlast    // frame_last
);
  import bd2_pkg::*;

  localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WEW   = $clog2(MAX_WIDTH + 1);
  localparam int IW    = (CW > 1) ? CW - 1 : 1;
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

  // Effective frame size, clamped when written.
  logic [WEW-1:0]   width_eff;
  logic [CFG_W-1:0] height_eff;
  logic [WEW-1:0]   used_w;
  logic [CFG_W-1:0] used_h;

  logic [CW-1:0]    col, col_next;
  logic [ROW_W-1:0] row, row_next;
  logic [PIX_W-1:0] held;

  logic [PIX_W:0]   line_mem [0:DEPTH-1];
  logic [PIX_W:0]   line_rd;

  logic             s1_valid;
  logic [PIX_W:0]   s1_pair;
  logic             s1_last;
  logic             out_valid;
  logic [PIX_W-1:0] out_pixel;
  logic             out_last;

  logic             accept, adv1, in_pair, is_last, mem_we, mem_rd_en, col_wrap;
  logic [IW-1:0]    idx;
  logic [PIX_W:0]   pair_sum;
  logic [PIX_W+1:0] block_sum;
  logic [31:0]      cfg_wide;
  logic [WEW-1:0]   width_cfg_next;
  logic [CFG_W-1:0] height_cfg_next;

  assign used_w = width_eff & ~WEW'(1);
  assign used_h = height_eff & ~CFG_W'(1);

  always_comb begin
    cfg_wide = 32'(cfg_data);
    if (cfg_wide == 32'd0) begin
      width_cfg_next = WEW'(1);
    end else if (cfg_wide > 32'(MAX_WIDTH)) begin
      width_cfg_next = WEW'(MAX_WIDTH);
    end else begin
      width_cfg_next = WEW'(cfg_wide);
    end
    if (cfg_wide == 32'd0) begin
      height_cfg_next = CFG_W'(1);
    end else if (cfg_wide > 32'(MAX_HEIGHT)) begin
      height_cfg_next = CFG_W'(MAX_HEIGHT);
    end else begin
      height_cfg_next = cfg_data;
    end
  end

  assign adv1     = !out_valid || m_tready;
  assign s_tready = !s1_valid || adv1;
  assign accept   = s_tvalid && s_tready;

  assign in_pair   = col[0] && (WEW'(col) < used_w) && (CFG_W'(row) < used_h);
  assign is_last   = (WEW'(col) == used_w - WEW'(1)) && (CFG_W'(row) == used_h - CFG_W'(1));
  assign idx       = IW'(col >> 1);
  assign pair_sum  = {1'b0, held} + {1'b0, s_tdata};
  assign mem_we    = accept && in_pair && !row[0];
  assign mem_rd_en = accept && in_pair && row[0];
  assign block_sum = {1'b0, line_rd} + {1'b0, s1_pair} + (PIX_W+2)'(2);

  always_comb begin
    col_wrap = ({1'b0, col} + (CW+1)'(1)) >= (CW+1)'(width_eff);
    col_next = col_wrap ? '0 : col + CW'(1);
    row_next = row;
    if (col_wrap) begin
      if (({1'b0, row} + (ROW_W+1)'(1)) >= (ROW_W+1)'(height_eff)) begin
        row_next = '0;
      end else begin
        row_next = row + ROW_W'(1);
      end
    end
  end

  // Configuration and raster counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WEW'(RST_W);
      height_eff <= CFG_W'(RESET_HEIGHT);
      col        <= '0;
      row        <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        width_eff <= width_cfg_next;
      end else begin
        height_eff <= height_cfg_next;
      end
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !col[0]) begin
      held <= s_tdata;
    end
  end

  // Line store: even rows write pair sums, the next odd row reads them back.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[idx] <= pair_sum;
    end
    if (mem_rd_en) begin
      line_rd <= line_mem[idx];
    end
  end

  // Stage one sits beside the registered read data; the output register follows it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (mem_rd_en) begin
        s1_valid <= 1'b1;
      end else if (adv1) begin
        s1_valid <= 1'b0;
      end
      if (adv1) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      s1_pair <= pair_sum;
      s1_last <= is_last;
    end
    if (adv1 && s1_valid) begin
      out_pixel <= block_sum[PIX_W+1:2];
      out_last  <= s1_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_pixel;
  assign m_tlast  = out_last;

  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_rd_en))
    else $error("line store written and read in the same cycle");

  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    (CW+1)'(col) < (CW+1)'(width_eff))
    else $error("column count outside the frame width");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && out_valid && !m_tready))
    else $error("input stalled with room in the result stages");

  a_read_fills_stage: assert property (@(posedge clk) disable iff (rst)
    mem_rd_en |=> s1_valid)
    else $error("line store read lost its result");

endmodule

// ----- bench/box_downsample_2x2_tb.sv -----
// Self-checking testbench for the 2x2 box-filter downsampler.
`timescale 1ns / 1ps

module box_downsample_2x2_tb;
  import bd2_pkg::*;

  localparam int LINE_DEPTH    = MAX_WIDTH_DEFAULT / 2;
  localparam int SLOT_W        = $clog2(LINE_DEPTH);
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS  = 1620;
  localparam int LARGE_RUN     = 64;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } block_average_t;

  class box_average_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int unsigned      column;
    int unsigned      row;
    logic [7:0]       held_left;
    logic [8:0]       pair_line [LINE_DEPTH];
    block_average_t   expected_averages [$];
    int               error_count;

    function new();
      width_reg   = CFG_W'(RESET_WIDTH);
      height_reg  = CFG_W'(RESET_HEIGHT);
      column      = 0;
      row         = 0;
      held_left   = '0;
      error_count = 0;
    endfunction

    function int unsigned clamp_size(logic [CFG_W-1:0] value, int unsigned limit);
      if (value == '0) return 1;
      if (32'(value) > limit) return limit;
      return 32'(value);
    endfunction

    // Any register write restarts the frame at the top-left pixel.
    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
      case (index)
        REG_FRAME_WIDTH: width_reg = value;
        REG_FRAME_HEIGHT: height_reg = value;
        default: ;
      endcase
      column = 0;
      row    = 0;
    endfunction

    function void note_pixel(logic [7:0] pixel);
      int unsigned       width;
      int unsigned       height;
      int unsigned       used_width;
      int unsigned       used_height;
      int unsigned       col;
      int unsigned       r;
      int unsigned       pair;
      int unsigned       block_sum;
      logic [SLOT_W-1:0] slot;
      block_average_t    result;
      width       = clamp_size(width_reg, MAX_WIDTH_DEFAULT);
      height      = clamp_size(height_reg, MAX_HEIGHT);
      used_width  = width & ~32'd1;
      used_height = height & ~32'd1;
      col = (column >= width) ? 0 : column;
      r   = (row >= height) ? 0 : row;
      if (col % 2 == 0) begin
        held_left = pixel;
      end else if (col < used_width && r < used_height) begin
        pair = 32'(held_left) + 32'(pixel);
        slot = SLOT_W'(col >> 1);
        if (r % 2 == 0) begin
          pair_line[slot] = pair[8:0];
        end else begin
          block_sum    = 32'(pair_line[slot]) + pair;
          result.pixel = 8'((block_sum + 2) >> 2);
          result.last  = (r == used_height - 1) && (col == used_width - 1);
          expected_averages.push_back(result);
        end
      end
      col++;
      if (col >= width) begin
        col = 0;
        r++;
        if (r >= height) r = 0;
      end
      column = col;
      row    = r;
    endfunction

    function int pending();
      return expected_averages.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
    endtask

    task check_average(logic [7:0] pixel, logic last);
      block_average_t want;
      if (expected_averages.size() == 0) begin
        report($sformatf("output pixel %0d with none expected", pixel));
        return;
      end
      want = expected_averages.pop_front();
      if (pixel !== want.pixel)
        report($sformatf("pixel %0d, expected %0d", pixel, want.pixel));
      if (last !== want.last)
        report($sformatf("tlast %0b, expected %0b", last, want.last));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;   // [7:0] pixel_in
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;        // [7:0] pixel_out
  logic                 m_tlast;        // frame_last

  box_average_scoreboard sb = new();
  bit                    steady = 1'b0;

  box_downsample_2x2 u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: values sampled at the edge are the ones the block saw.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_average(m_tdata, m_tlast);
    end
    m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 9);
  end

  function logic [7:0] pick_pixel();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task send_pixel(logic [7:0] pixel);
    while (!steady && $urandom_range(0, 99) < 9) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pixel;
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(pixel);
  endtask

  task send_run(int count);
    for (int i = 0; i < count; i++) begin
      send_pixel(pick_pixel());
    end
  endtask

  // Waits until every expected average has left, then lets the pipeline empty,
  // since a trailing pixel may still be in flight without causing a result.
  task settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_frame_regs(bit do_width, logic [CFG_W-1:0] width,
                        bit do_height, logic [CFG_W-1:0] height);
    if (do_width) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_FRAME_WIDTH;
      cfg_data  <= width;
      @(posedge clk);
      sb.set_register(REG_FRAME_WIDTH, width);
    end
    if (do_height) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_FRAME_HEIGHT;
      cfg_data  <= height;
      @(posedge clk);
      sb.set_register(REG_FRAME_HEIGHT, height);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          random_items;
    int          phase;
    int unsigned width;
    int unsigned height;
    int unsigned frame;
    int          count;
    int unsigned mode;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // A couple of pixels at the reset geometry; no block completes.
    send_pixel(8'h00);
    send_pixel(8'hFF);
    settle();

    // Smallest frame that yields output: full scale, zero, and rounding.
    write_frame_regs(1'b1, 13'd2, 1'b1, 13'd2);
    repeat (4) send_pixel(8'hFF);
    repeat (4) send_pixel(8'h00);
    send_pixel(8'h01);
    send_pixel(8'h01);
    send_pixel(8'h00);
    send_pixel(8'h00);
    settle();

    // Odd width and height: the last column and the bottom row are dropped.
    write_frame_regs(1'b1, 13'd3, 1'b1, 13'd3);
    send_run(9);
    settle();

    // Zero sizes count as one, which is too small to pair.
    write_frame_regs(1'b1, 13'd0, 1'b1, 13'd0);
    send_run(2);
    settle();
    write_frame_regs(1'b1, 13'd5, 1'b1, 13'd1);
    send_run(5);

    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      steady = (phase >= 3 && phase < 9);
      width  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(2, 24);
      height = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(2, 12);
      mode   = (phase == 0) ? 3 : $urandom_range(0, 5);
      write_frame_regs(mode != 1, CFG_W'(width), mode != 0, CFG_W'(height));
      frame = sb.clamp_size(sb.width_reg, MAX_WIDTH_DEFAULT) *
              sb.clamp_size(sb.height_reg, MAX_HEIGHT);
      if ($urandom_range(0, 1) == 1)
        count = frame + $urandom_range(0, frame);
      else
        count = $urandom_range(1, frame);
      if (count > 600) count = 600;
      if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
      send_run(count);
      random_items += count;
      phase++;
    end
    steady = 1'b0;

    // Widest frame, an oversized width, and an oversized height.
    settle();
    write_frame_regs(1'b1, 13'd4096, 1'b1, 13'd2);
    send_run(LARGE_RUN);
    settle();
    write_frame_regs(1'b1, 13'd8191, 1'b0, 13'd0);
    send_run(LARGE_RUN);
    settle();
    write_frame_regs(1'b1, 13'd2, 1'b1, 13'd8191);
    send_run(LARGE_RUN);
    settle();

    if (sb.error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
